>>> rtl/clnws_pkg.sv
// shared types, register codes and constants for the lcd nibble write sequencer
package clnws_pkg;

  localparam int TICK_COUNTER_BITS_DEF = 16;
  localparam int CFG_WIDTH             = 16;
  localparam int QUEUE_DEPTH           = 2;

  // request codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_COMMAND = 2'd1;
  localparam logic [1:0] OP_CHAR    = 2'd2;
  localparam logic [1:0] OP_CURSOR  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_COMMAND_ENABLE = 2'd0;
  localparam logic [1:0] CFG_DATA_ENABLE    = 2'd1;
  localparam logic [1:0] CFG_GAP            = 2'd2;
  localparam logic [1:0] CFG_CLEAR_WAIT     = 2'd3;

  localparam logic [CFG_WIDTH-1:0] COMMAND_ENABLE_RESET = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] DATA_ENABLE_RESET    = 16'd1;
  localparam logic [CFG_WIDTH-1:0] GAP_RESET            = 16'd100;
  localparam logic [CFG_WIDTH-1:0] CLEAR_WAIT_RESET     = 16'd2000;

  localparam logic [2:0] INIT_COUNT       = 3'd6;
  localparam logic [2:0] INIT_CLEAR_INDEX = 3'd4;

  localparam logic [7:0] ROW0_BASE = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'hC0;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HI_ON,
    PH_HI_OFF,
    PH_LO_ON,
    PH_LO_OFF,
    PH_CLEAR
  } phase_t;

  // one classified request as it sits in the queue
  typedef struct packed {
    logic       is_tick;
    logic       select;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h0e;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/char_lcd_nibble_write_sequencer.sv
// top level of the 4-bit character lcd write sequencer
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    operation, byte_value, cursor_row, cursor_column
//   out      output     out_valid / out_ready  rs_pin, enable_pin, bus_nibble, busy_res, rejected
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one beat in and one result out per cycle, sustained while out_ready stays high; a result passes
// through the queue slot and then the result register of the sequencer
// the two-entry queue keeps input accepted for two beats while the output is stalled
// reset clears the queue and the sequencer; init then advances on incoming ticks
// cfg_ready is always high, and each write goes straight into its config register
module char_lcd_nibble_write_sequencer
  import clnws_pkg::*;
#(
  parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  input  logic [7:0]           byte_value,
  input  logic                 cursor_row,
  input  logic [5:0]           cursor_column,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 rs_pin,
  output logic                 enable_pin,
  output logic [3:0]           bus_nibble,
  output logic                 busy_res,
  output logic                 rejected,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  item_t       front_item;
  item_t       head;
  queue_stat_t qstat;
  logic        push;
  logic        pop;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  clnws_front u_front (
    .operation     (operation),
    .byte_value    (byte_value),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column),
    .item          (front_item)
  );

  clnws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  clnws_back #(
    .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rs_pin     (rs_pin),
    .enable_pin (enable_pin),
    .bus_nibble (bus_nibble),
    .busy_res   (busy_res),
    .rejected   (rejected)
  );

`ifndef SYNTH
  // after reset the queue is empty and nothing is shown
  a_reset_clean: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("queue or result register not cleared by reset");

  // a dropped request only happens while busy
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> busy_res)
    else $error("request rejected while idle");

  // enable only strobes during a sequence
  a_enable_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && enable_pin |-> busy_res)
    else $error("enable high while not busy");

  // the sequencer never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");
`endif

endmodule

>>> rtl/clnws_front.sv
// front end: turns an incoming beat into a classified queue entry
module clnws_front
  import clnws_pkg::*;
(
  input  logic [1:0] operation,
  input  logic [7:0] byte_value,
  input  logic       cursor_row,
  input  logic [5:0] cursor_column,
  output item_t      item
);

  logic [7:0] cursor_addr;

  assign cursor_addr = (cursor_row ? ROW1_BASE : ROW0_BASE) + {2'b00, cursor_column};

  always_comb begin
    item = '0;
    case (operation)
      OP_TICK: begin
        item.is_tick = 1'b1;
      end
      OP_COMMAND: begin
        item.data_byte = byte_value;
      end
      OP_CHAR: begin
        item.select    = 1'b1;
        item.data_byte = byte_value;
      end
      OP_CURSOR: begin
        item.data_byte = cursor_addr;
      end
      default: begin
        item.is_tick = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/clnws_queue.sv
// small fifo between the front end and the sequencer
module clnws_queue
  import clnws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       push_item,
  input  logic        pop,
  output item_t       head,
  output queue_stat_t stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/clnws_back.sv
// back end: write sequencer, init walk, config registers and the result register
module clnws_back
  import clnws_pkg::*;
#(
  parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  input  item_t                head,
  input  queue_stat_t          qstat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 rs_pin,
  output logic                 enable_pin,
  output logic [3:0]           bus_nibble,
  output logic                 busy_res,
  output logic                 rejected
);

  localparam int W     = TICK_COUNTER_BITS;
  localparam int CMP_W = ((W > CFG_WIDTH) ? W : CFG_WIDTH) + 1;

  logic [CFG_WIDTH-1:0] command_enable_ticks;
  logic [CFG_WIDTH-1:0] data_enable_ticks;
  logic [CFG_WIDTH-1:0] gap_ticks;
  logic [CFG_WIDTH-1:0] clear_wait_ticks;

  phase_t     phase, phase_next;
  logic [W-1:0] tick_counter, tick_counter_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_select, held_select_next;
  logic [2:0] init_index, init_index_next;
  logic       init_finished, init_finished_next;
  logic       rejected_next;

  logic                 fire;
  logic [CFG_WIDTH-1:0] enable_limit;
  logic [CFG_WIDTH-1:0] limit;
  logic [W:0]           cnt_inc;
  logic                 done;
  logic                 do_launch;
  logic [2:0]           launch_idx;

  assign cfg_ready = 1'b1;
  assign fire      = !qstat.empty && (!out_valid || out_ready);
  assign pop       = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_enable_ticks <= COMMAND_ENABLE_RESET;
      data_enable_ticks    <= DATA_ENABLE_RESET;
      gap_ticks            <= GAP_RESET;
      clear_wait_ticks     <= CLEAR_WAIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COMMAND_ENABLE: command_enable_ticks <= cfg_data;
        CFG_DATA_ENABLE:    data_enable_ticks    <= cfg_data;
        CFG_GAP:            gap_ticks            <= cfg_data;
        CFG_CLEAR_WAIT:     clear_wait_ticks     <= cfg_data;
        default:            ;
      endcase
    end
  end

  assign enable_limit = held_select ? data_enable_ticks : command_enable_ticks;

  always_comb begin
    case (phase)
      PH_HI_ON, PH_LO_ON:   limit = enable_limit;
      PH_HI_OFF, PH_LO_OFF: limit = gap_ticks;
      PH_CLEAR:             limit = clear_wait_ticks;
      default:              limit = gap_ticks;
    endcase
  end

  // a zero limit ends on the first tick, a saturated counter ends the interval
  assign cnt_inc = {1'b0, tick_counter} + 1'b1;
  assign done    = (CMP_W'(cnt_inc) >= CMP_W'(limit)) || (tick_counter == '1);

  always_comb begin
    phase_next         = phase;
    tick_counter_next  = tick_counter;
    held_byte_next     = held_byte;
    held_select_next   = held_select;
    init_index_next    = init_index;
    init_finished_next = init_finished;
    rejected_next      = 1'b0;
    do_launch          = 1'b0;
    launch_idx         = init_index;

    if (fire) begin
      if (head.is_tick) begin
        if (phase != PH_IDLE) begin
          tick_counter_next = done ? '0 : cnt_inc[W-1:0];
        end
        case (phase)
          PH_HI_ON: begin
            if (done) phase_next = PH_HI_OFF;
          end
          PH_HI_OFF: begin
            if (done) phase_next = PH_LO_ON;
          end
          PH_LO_ON: begin
            if (done) phase_next = PH_LO_OFF;
          end
          PH_LO_OFF: begin
            if (done) begin
              if (init_finished) begin
                phase_next = PH_IDLE;
              end else if (init_index == INIT_CLEAR_INDEX && clear_wait_ticks != '0) begin
                init_index_next = init_index + 1'b1;
                phase_next      = PH_CLEAR;
              end else begin
                init_index_next = init_index + 1'b1;
                launch_idx      = init_index + 1'b1;
                do_launch       = 1'b1;
              end
            end
          end
          PH_CLEAR: begin
            if (done) do_launch = 1'b1;
          end
          default: begin
            if (!init_finished) do_launch = 1'b1;
          end
        endcase
      end else if (phase != PH_IDLE || !init_finished) begin
        rejected_next = 1'b1;
      end else begin
        held_byte_next    = head.data_byte;
        held_select_next  = head.select;
        phase_next        = PH_HI_ON;
        tick_counter_next = '0;
      end

      // next init byte, or the end of init
      if (do_launch) begin
        tick_counter_next = '0;
        if (launch_idx < INIT_COUNT) begin
          held_byte_next   = init_byte(launch_idx);
          held_select_next = 1'b0;
          phase_next       = PH_HI_ON;
        end else begin
          init_finished_next = 1'b1;
          phase_next         = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_counter  <= '0;
      held_byte     <= '0;
      held_select   <= 1'b0;
      init_index    <= '0;
      init_finished <= 1'b0;
    end else begin
      phase         <= phase_next;
      tick_counter  <= tick_counter_next;
      held_byte     <= held_byte_next;
      held_select   <= held_select_next;
      init_index    <= init_index_next;
      init_finished <= init_finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // pin levels after this beat
  always_ff @(posedge clk) begin
    if (fire) begin
      rs_pin     <= held_select_next;
      enable_pin <= (phase_next == PH_HI_ON) || (phase_next == PH_LO_ON);
      bus_nibble <= ((phase_next == PH_HI_ON) || (phase_next == PH_HI_OFF))
                    ? held_byte_next[7:4] : held_byte_next[3:0];
      busy_res   <= (phase_next != PH_IDLE) || !init_finished_next;
      rejected   <= rejected_next;
    end
  end

endmodule

>>> tb/sv/char_lcd_nibble_write_sequencer_tb.sv
`timescale 1ns / 100ps
// testbench for the lcd nibble write sequencer: pin levels of every beat against a predictor
module char_lcd_nibble_write_sequencer_tb;
  import clnws_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 290;

  typedef struct {
    logic       rs;
    logic       en;
    logic [3:0] nib;
    logic       busy;
    logic       rej;
  } pin_levels_t;

  // tracks the sequencer state and queues the pin levels each accepted beat should produce
  class pin_level_tracker;
    logic [15:0] cmd_en_ticks;
    logic [15:0] data_en_ticks;
    logic [15:0] gap_ticks;
    logic [15:0] clear_ticks;
    phase_t      phase;
    logic [15:0] count;
    logic [7:0]  held_byte;
    logic        held_sel;
    logic [2:0]  boot_idx;
    bit          boot_done;
    logic [7:0]  boot_bytes [6];
    pin_levels_t expected_q [$];
    int          mismatches;

    function new();
      cmd_en_ticks  = COMMAND_ENABLE_RESET;
      data_en_ticks = DATA_ENABLE_RESET;
      gap_ticks     = GAP_RESET;
      clear_ticks   = CLEAR_WAIT_RESET;
      phase         = PH_IDLE;
      count         = '0;
      held_byte     = '0;
      held_sel      = 1'b0;
      boot_idx      = '0;
      boot_done     = 1'b0;
      boot_bytes    = '{8'h33, 8'h32, 8'h28, 8'h0e, 8'h01, 8'h06};
      mismatches    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CFG_COMMAND_ENABLE: cmd_en_ticks = value;
        CFG_DATA_ENABLE:    data_en_ticks = value;
        CFG_GAP:            gap_ticks = value;
        CFG_CLEAR_WAIT:     clear_ticks = value;
        default:            ;
      endcase
    endfunction

    function bit busy();
      return (phase != PH_IDLE) || !boot_done;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // zero limit behaves like one tick; a saturated counter also ends the interval
    function bit interval_done(logic [15:0] limit);
      bit hit;
      hit = (int'(count) + 1 >= int'(limit)) || (count == '1);
      count = hit ? 16'd0 : count + 16'd1;
      return hit;
    endfunction

    function void launch(logic [7:0] b, logic sel);
      held_byte = b;
      held_sel  = sel;
      phase     = PH_HI_ON;
      count     = '0;
    endfunction

    function void next_boot();
      if (boot_idx < INIT_COUNT) begin
        launch(boot_bytes[boot_idx], 1'b0);
      end else begin
        boot_done = 1'b1;
        phase     = PH_IDLE;
        count     = '0;
      end
    endfunction

    function void end_write();
      if (boot_done) begin
        phase = PH_IDLE;
        count = '0;
      end else if (boot_idx == INIT_CLEAR_INDEX && clear_ticks != 0) begin
        boot_idx = boot_idx + 3'd1;
        phase    = PH_CLEAR;
        count    = '0;
      end else begin
        boot_idx = boot_idx + 3'd1;
        next_boot();
      end
    endfunction

    function void step_tick();
      logic [15:0] en_limit;
      en_limit = held_sel ? data_en_ticks : cmd_en_ticks;
      case (phase)
        PH_HI_ON:  if (interval_done(en_limit)) phase = PH_HI_OFF;
        PH_HI_OFF: if (interval_done(gap_ticks)) phase = PH_LO_ON;
        PH_LO_ON:  if (interval_done(en_limit)) phase = PH_LO_OFF;
        PH_LO_OFF: if (interval_done(gap_ticks)) end_write();
        PH_CLEAR:  if (interval_done(clear_ticks)) next_boot();
        default:   if (!boot_done) next_boot();
      endcase
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] b, logic row, logic [5:0] col);
      pin_levels_t lv;
      logic [7:0]  addr;
      lv.rej = 1'b0;
      if (op == OP_TICK) begin
        step_tick();
      end else if (busy()) begin
        lv.rej = 1'b1;
      end else if (op == OP_COMMAND) begin
        launch(b, 1'b0);
      end else if (op == OP_CHAR) begin
        launch(b, 1'b1);
      end else begin
        addr = (row ? ROW1_BASE : ROW0_BASE) + {2'b00, col};
        launch(addr, 1'b0);
      end
      lv.rs   = held_sel;
      lv.en   = (phase == PH_HI_ON) || (phase == PH_LO_ON);
      lv.nib  = (phase == PH_HI_ON || phase == PH_HI_OFF) ? held_byte[7:4] : held_byte[3:0];
      lv.busy = busy();
      expected_q.push_back(lv);
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
    endfunction

    function void check_levels(logic rs, logic en, logic [3:0] nib, logic bsy, logic rej);
      pin_levels_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none got rs %b en %b nib %h busy %b rej %b",
                 $time, rs, en, nib, bsy, rej);
        return;
      end
      want = expected_q.pop_front();
      compare_field("rs_pin", {3'b000, want.rs}, {3'b000, rs});
      compare_field("enable_pin", {3'b000, want.en}, {3'b000, en});
      compare_field("bus_nibble", want.nib, nib);
      compare_field("busy_res", {3'b000, want.busy}, {3'b000, bsy});
      compare_field("rejected", {3'b000, want.rej}, {3'b000, rej});
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = OP_TICK;
  logic [7:0]  byte_value = '0;
  logic        cursor_row = 1'b0;
  logic [5:0]  cursor_column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        rs_pin;
  logic        enable_pin;
  logic [3:0]  bus_nibble;
  logic        busy_res;
  logic        rejected;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_COMMAND_ENABLE;
  logic [15:0] cfg_data = '0;

  pin_level_tracker tracker;
  int unsigned      max_in_gap = 10;
  int unsigned      max_out_stall = 10;
  int unsigned      cycle_count = 0;

  char_lcd_nibble_write_sequencer uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .byte_value    (byte_value),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .rs_pin        (rs_pin),
    .enable_pin    (enable_pin),
    .bus_nibble    (bus_nibble),
    .busy_res      (busy_res),
    .rejected      (rejected),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // valid stays high across back-to-back beats; it only drops ahead of a gap
  task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic row,
                           input logic [5:0] col);
    int unsigned gap;
    gap = $urandom_range(0, max_in_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    byte_value    <= b;
    cursor_row    <= row;
    cursor_column <= col;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.note_request(op, b, row, col);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              6'($urandom_range(0, 63)));
  endtask

  task automatic send_random_request();
    send_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              6'($urandom_range(0, 63)));
  endtask

  task automatic run_until_idle();
    while (tracker.busy()) send_tick();
  endtask

  // drop valid in the step of the last acceptance and wait for every result
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.write_reg(idx, value);
  endtask

  task automatic set_regs(input logic [15:0] cmd_en, input logic [15:0] data_en,
                          input logic [15:0] gap, input logic [15:0] clear_wait);
    cfg_beat(CFG_COMMAND_ENABLE, cmd_en);
    cfg_beat(CFG_DATA_ENABLE, data_en);
    cfg_beat(CFG_GAP, gap);
    cfg_beat(CFG_CLEAR_WAIT, clear_wait);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall;
    wait (rst === 1'b0);
    forever begin
      stall = $urandom_range(0, max_out_stall);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_levels(rs_pin, enable_pin, bus_nibble, busy_res, rejected);
    end
  end

  initial begin : main_flow
    int unsigned roll;
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero enable and gap act as one tick, so init runs short
    set_regs(16'd0, 16'd0, 16'd0, 16'($urandom_range(0, 3)));
    send_item(OP_CURSOR, 8'h00, 1'b1, 6'h3f);
    send_tick();
    send_tick();
    send_item(OP_COMMAND, 8'hff, 1'b0, 6'h00);
    run_until_idle();
    send_item(OP_CHAR, 8'hff, 1'b1, 6'h3f);
    send_item(OP_COMMAND, 8'h00, 1'b0, 6'h00);
    run_until_idle();
    send_item(OP_COMMAND, 8'h00, 1'b1, 6'h2a);
    run_until_idle();
    send_item(OP_CURSOR, 8'hff, 1'b1, 6'h3f);
    run_until_idle();
    send_item(OP_CURSOR, 8'h00, 1'b0, 6'h00);
    run_until_idle();
    send_item(OP_CHAR, 8'h00, 1'b0, 6'h15);
    run_until_idle();
    send_tick();

    // widest strobes and gaps, cut short by shrinking the limit below the running count
    settle();
    max_in_gap = 0;
    max_out_stall = 0;
    set_regs(16'hffff, 16'hffff, 16'd1, 16'hffff);
    send_item(OP_COMMAND, 8'($urandom_range(0, 255)), 1'b0, 6'h00);
    send_random_request();
    repeat (20) send_tick();
    settle();
    set_regs(16'd1, 16'd1, 16'd1, 16'd0);
    run_until_idle();
    settle();
    set_regs(16'd1, 16'd1, 16'hffff, 16'd0);
    send_item(OP_CHAR, 8'($urandom_range(0, 255)), 1'b1, 6'h3f);
    send_random_request();
    repeat (20) send_tick();
    settle();
    set_regs(16'd1, 16'd1, 16'd1, 16'd0);
    run_until_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      set_regs(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
               16'($urandom_range(0, 6)), 16'($urandom_range(0, 65535)));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 50 == 0) begin
          max_in_gap    = ($urandom_range(0, 2) == 0) ? 0 : 10;
          max_out_stall = ($urandom_range(0, 2) == 0) ? 0 : 10;
        end
        roll = $urandom_range(0, 9);
        if (!tracker.busy() && roll < 7) begin
          send_random_request();
        end else if (tracker.busy() && roll == 0) begin
          send_random_request();
        end else begin
          send_tick();
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/clnws_pkg.sv
rtl/clnws_front.sv
rtl/clnws_queue.sv
rtl/clnws_back.sv
rtl/char_lcd_nibble_write_sequencer.sv
tb/sv/char_lcd_nibble_write_sequencer_tb.sv
